/* rtl/qspc_pkg.sv */
package qspc_pkg;

    localparam int RUNTIME_W  = 64;
    localparam int ELAPSED_W  = 32;
    localparam int QUOTA_W    = 10;
    localparam int LOAD_P_W   = 15;
    localparam int STORE_P_W  = 21;
    localparam int USAGE_W    = 32;
    localparam int LOAD_IDX_W = 6;
    localparam int STORE_IDX_W = 3;
    localparam int USED_W     = 40;
    localparam int SCALED_W   = 43;
    localparam int DIV_CNT_W  = 6;

    // divide by five as a multiply by ceil(2^37 / 5), exact below 5 * 2^32
    localparam int RECIP_W     = 35;
    localparam int RECIP_SPLIT = 17;
    localparam int RECIP_SHIFT = 37;
    localparam logic [RECIP_W-1:0]  DIV5_RECIP       = 35'd27487790695;
    localparam logic [SCALED_W-1:0] SMOOTH_SAT_BOUND = 43'd21474836480;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 72;

    localparam int DEF_NUM_LOAD_PERIODS  = 35;
    localparam int DEF_NUM_STORE_PERIODS = 5;
    localparam int DEF_LOAD_START_INDEX  = 10;

    localparam int LOAD_TABLE_SIZE  = 35;
    localparam int STORE_TABLE_SIZE = 5;

    localparam logic [QUOTA_W-1:0]   USAGE_MARGIN = 10'd5;

    localparam logic [LOAD_P_W-1:0] LOAD_TABLE [LOAD_TABLE_SIZE] = '{
        15'd53,    15'd101,   15'd127,   15'd149,   15'd173,   15'd199,   15'd293,
        15'd401,   15'd499,   15'd599,   15'd701,   15'd797,   15'd907,   15'd997,
        15'd1201,  15'd1399,  15'd1601,  15'd1801,  15'd1999,  15'd2503,  15'd3001,
        15'd3499,  15'd4001,  15'd4507,  15'd4999,  15'd6007,  15'd7001,  15'd7993,
        15'd9001,  15'd10007, 15'd12007, 15'd13999, 15'd16001, 15'd17989, 15'd19997
    };

    localparam logic [STORE_P_W-1:0] STORE_TABLE [STORE_TABLE_SIZE] = '{
        21'd100003, 21'd300007, 21'd600011, 21'd1000003, 21'd1500003
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SCALE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic prime;
        logic div_first;
        logic scale;
        logic mul_lo;
        logic mul_hi;
        logic update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic quota_zero;
        logic primed;
        logic elapsed_zero;
        logic avg_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

/* rtl/quota_sampling_period_control.sv */
// channel   direction  handshake              payload
// s         in         i_s_tvalid/o_s_tready  i_s_tdata: runtime_ns, interval_us
// m         out        o_m_tvalid/i_m_tready  o_m_tdata: ld_period, st_period,
//                                             period_changed, smoothed_usage
// cfg       in         i_cfg_wen              i_cfg_wdata: cpu_quota_permille
//
// one item at a time, accepted only while idle; an item with a zero old average
// skips the scaling and multiply steps, and an ignored, priming or zero-quota
// item goes straight to the output step; the run-time quotient comes from the
// 64-step restoring divider; the divide by ten is a two-half reciprocal multiply
// reset is synchronous and active low; no clearing pass
// the result sits in an output register, so a stalled output only holds up the
// following item at its final step
module quota_sampling_period_control #(
    parameter int NUM_LOAD_PERIODS  = qspc_pkg::DEF_NUM_LOAD_PERIODS,
    parameter int NUM_STORE_PERIODS = qspc_pkg::DEF_NUM_STORE_PERIODS,
    parameter int LOAD_START_INDEX  = qspc_pkg::DEF_LOAD_START_INDEX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [qspc_pkg::QUOTA_W-1:0]   i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // runtime_ns [63:0], interval_us [95:64]
    input  logic [qspc_pkg::S_DATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // ld_period [14:0], st_period [35:15], period_changed [36],
    // smoothed_usage [68:37], zero [71:69]
    output logic [qspc_pkg::M_DATA_W-1:0]  o_m_tdata
);
    import qspc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    qspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qspc_dp #(
        .NUM_LOAD_PERIODS  (NUM_LOAD_PERIODS),
        .NUM_STORE_PERIODS (NUM_STORE_PERIODS),
        .LOAD_START_INDEX  (LOAD_START_INDEX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

/* rtl/qspc_ctrl.sv */
module qspc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  qspc_pkg::t_sts  i_sts,
    output qspc_pkg::t_cmd  o_cmd
);
    import qspc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   s_accept;

    assign s_accept = i_s_tvalid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.quota_zero || !i_sts.primed || i_sts.elapsed_zero) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) n_state = i_sts.avg_zero ? ST_UPDATE : ST_SCALE;
            end
            ST_SCALE:  n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_OUT;
            ST_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = s_accept;
            end
            ST_CHECK: begin
                if (!i_sts.quota_zero) begin
                    o_cmd.prime     = !i_sts.primed;
                    o_cmd.div_first = i_sts.primed && !i_sts.elapsed_zero;
                end
            end
            ST_SCALE:  o_cmd.scale    = 1'b1;
            ST_MUL_LO: o_cmd.mul_lo   = 1'b1;
            ST_MUL_HI: o_cmd.mul_hi   = 1'b1;
            ST_UPDATE: o_cmd.update   = 1'b1;
            ST_OUT:    o_cmd.out_load = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/qspc_dp.sv */
module qspc_dp #(
    parameter int NUM_LOAD_PERIODS  = qspc_pkg::DEF_NUM_LOAD_PERIODS,
    parameter int NUM_STORE_PERIODS = qspc_pkg::DEF_NUM_STORE_PERIODS,
    parameter int LOAD_START_INDEX  = qspc_pkg::DEF_LOAD_START_INDEX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [qspc_pkg::QUOTA_W-1:0]   i_cfg_wdata,
    input  logic [qspc_pkg::S_DATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [qspc_pkg::M_DATA_W-1:0]  o_m_tdata,
    input  qspc_pkg::t_cmd                 i_cmd,
    output qspc_pkg::t_sts                 o_sts
);
    import qspc_pkg::*;

    localparam int LOAD_LAST  =
        (NUM_LOAD_PERIODS < LOAD_TABLE_SIZE ? NUM_LOAD_PERIODS : LOAD_TABLE_SIZE) - 1;
    localparam int STORE_LAST =
        (NUM_STORE_PERIODS < STORE_TABLE_SIZE ? NUM_STORE_PERIODS : STORE_TABLE_SIZE) - 1;
    localparam int PLO_W  = RECIP_SPLIT + RECIP_W;
    localparam int PHI_W  = 2 * RECIP_W - RECIP_SPLIT;
    localparam int PROD_W = 2 * RECIP_W;

    logic [QUOTA_W-1:0]     r_quota;
    logic [RUNTIME_W-1:0]   r_runtime;
    logic [ELAPSED_W-1:0]   r_elapsed;
    logic [RUNTIME_W-1:0]   r_last_runtime;
    logic                   r_primed;
    logic [USAGE_W-1:0]     r_avg;
    logic [LOAD_IDX_W-1:0]  r_load_idx;
    logic [STORE_IDX_W-1:0] r_store_idx;
    logic                   r_changed;

    // restoring divider for the run-time quotient, one quotient bit per cycle
    logic [RUNTIME_W-1:0]   r_quo;
    logic [ELAPSED_W-1:0]   r_rem;
    logic [ELAPSED_W-1:0]   r_dvs;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_busy;
    logic [PLO_W-1:0]       r_plo;

    logic                   r_m_valid;
    logic [LOAD_P_W-1:0]    r_load_p;
    logic [STORE_P_W-1:0]   r_store_p;
    logic                   r_m_changed;
    logic [USAGE_W-1:0]     r_m_usage;

    logic [ELAPSED_W:0]     trial;
    logic                   trial_ge;
    logic [USED_W-1:0]      used_c;
    logic [SCALED_W-1:0]    scaled;
    logic [PLO_W-1:0]       mul_lo_c;
    logic [PHI_W-1:0]       mul_hi_c;
    logic [PROD_W-1:0]      recip_sum;
    logic                   smooth_sat;
    logic [USAGE_W-1:0]     smooth;
    logic [QUOTA_W:0]       upper;
    logic [QUOTA_W-1:0]     lower;
    logic                   go_up;
    logic                   go_down;
    logic [LOAD_IDX_W-1:0]  load_sel;
    logic [STORE_IDX_W-1:0] store_sel;
    logic                   out_free;

    assign trial    = {r_rem, r_quo[RUNTIME_W-1]};
    assign trial_ge = trial >= {1'b0, r_dvs};

    // (8 * used + 2 * avg) / 10 taken as (4 * used + avg) / 5
    assign used_c = (|r_quo[RUNTIME_W-1:USED_W]) ? '1 : r_quo[USED_W-1:0];
    assign scaled = {1'b0, used_c, 2'b00} + {(SCALED_W-USAGE_W)'(0), r_avg};

    // reciprocal product in two halves of the dividend, one per cycle
    assign mul_lo_c   = PLO_W'(r_quo[RECIP_SPLIT-1:0]) * PLO_W'(DIV5_RECIP);
    assign mul_hi_c   = PHI_W'(r_quo[RECIP_W-1:RECIP_SPLIT]) * PHI_W'(DIV5_RECIP);
    assign recip_sum  = {mul_hi_c, RECIP_SPLIT'(0)} + {(PROD_W-PLO_W)'(0), r_plo};
    assign smooth_sat = r_quo[SCALED_W-1:0] >= SMOOTH_SAT_BOUND;

    assign smooth = (|r_quo[RUNTIME_W-1:USAGE_W]) ? '1 : r_quo[USAGE_W-1:0];

    assign upper = {1'b0, r_quota} + {1'b0, USAGE_MARGIN};
    assign lower = (r_quota > USAGE_MARGIN) ? r_quota - USAGE_MARGIN : '0;

    assign go_up   = (smooth > USAGE_W'(upper)) &&
                     (({1'b0, r_load_idx} + 7'd1) < 7'(NUM_LOAD_PERIODS));
    assign go_down = !go_up && (smooth < USAGE_W'(lower)) && (r_load_idx != '0);

    assign load_sel  = (int'(r_load_idx) > LOAD_LAST) ? LOAD_IDX_W'(LOAD_LAST) : r_load_idx;
    assign store_sel = (int'(r_store_idx) > STORE_LAST) ? STORE_IDX_W'(STORE_LAST)
                                                        : r_store_idx;

    assign out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quota <= '0;
        end else if (i_cfg_wen) begin
            r_quota <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_runtime <= i_s_tdata[RUNTIME_W-1:0];
            r_elapsed <= i_s_tdata[RUNTIME_W +: ELAPSED_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_runtime <= '0;
            r_primed       <= 1'b0;
            r_avg          <= '0;
            r_load_idx     <= LOAD_IDX_W'(LOAD_START_INDEX);
            r_store_idx    <= '0;
            r_changed      <= 1'b0;
        end else begin
            if (i_cmd.load_in) r_changed <= 1'b0;
            if (i_cmd.prime) begin
                r_last_runtime <= r_runtime;
                r_primed       <= 1'b1;
            end
            if (i_cmd.update) begin
                r_last_runtime <= r_runtime;
                r_avg          <= smooth;
                r_changed      <= go_up || go_down;
                if (go_up) begin
                    r_load_idx <= r_load_idx + 1'b1;
                    if (({1'b0, r_store_idx} + 4'd1) < 4'(NUM_STORE_PERIODS)) begin
                        r_store_idx <= r_store_idx + 1'b1;
                    end
                end else if (go_down) begin
                    r_load_idx <= r_load_idx - 1'b1;
                    if (r_store_idx != '0) r_store_idx <= r_store_idx - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.div_first) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == '1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_first) begin
            r_quo <= r_runtime - r_last_runtime;
            r_rem <= '0;
            r_dvs <= r_elapsed;
        end else if (i_cmd.scale) begin
            r_quo <= {(RUNTIME_W-SCALED_W)'(0), scaled};
        end else if (i_cmd.mul_hi) begin
            r_quo <= smooth_sat ? '1
                                : {(RUNTIME_W-USAGE_W)'(0), recip_sum[RECIP_SHIFT +: USAGE_W]};
        end else if (r_busy) begin
            r_quo <= {r_quo[RUNTIME_W-2:0], trial_ge};
            r_rem <= trial_ge ? ELAPSED_W'(trial - {1'b0, r_dvs}) : trial[ELAPSED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_plo <= mul_lo_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_load_p    <= LOAD_TABLE[load_sel];
            r_store_p   <= STORE_TABLE[store_sel];
            r_m_changed <= r_changed;
            r_m_usage   <= r_avg;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'b000, r_m_usage, r_m_changed, r_store_p, r_load_p};

    always_comb begin
        o_sts.quota_zero   = (r_quota == '0);
        o_sts.primed       = r_primed;
        o_sts.elapsed_zero = (r_elapsed == '0);
        o_sts.avg_zero     = (r_avg == '0);
        o_sts.div_done     = r_busy && (r_cnt == '1);
        o_sts.out_free     = out_free;
    end

endmodule
